// ===== hdl/dmssl_pkg.sv =====
// ----------------------------------------------------------------------------
// dmssl_pkg
// Shared types and constants for the decimating mean servo step limiter:
// register map, configuration record, divider request and response words.
// ----------------------------------------------------------------------------
package dmssl_pkg;

   // Field and datapath widths
   localparam int SAMPLE_W   = 12;
   localparam int SUM_W      = 18;
   localparam int MEAN_W     = 12;
   localparam int DUTY_W     = 16;
   localparam int WAIT_W     = 16;
   localparam int STEP_W     = 8;
   localparam int HOLD_W     = 10;
   localparam int SCALE_W    = 8;
   localparam int PROD_W     = 29;   // signed mean * span
   localparam int WPROD_W    = 24;   // diff * wait scale

   // Divide by constant: floor(n / d) = (n * ceil(2^k / d)) >> k, exact for
   // the dividend range noted with each of the shift counts used here
   localparam int DIV_W      = 28;
   localparam int RECIP_W    = 29;
   localparam int SHIFT_W    = 6;
   localparam int MPROD_W    = DIV_W + RECIP_W;

   localparam logic [MEAN_W-1:0] FULL_SCALE   = 12'd4095;
   localparam int                TENTHS_SCALE = 10;

   // duty mapping: magnitude below 2^28, divisor 4095
   localparam logic [SHIFT_W-1:0] MAP_SHIFT = 6'd40;
   localparam logic [RECIP_W-1:0] MAP_RECIP =
      RECIP_W'(((64'd1 << MAP_SHIFT) + 64'(FULL_SCALE) - 64'd1) / 64'(FULL_SCALE));

   // wait in tenths: dividend below 2^24, divisor 10
   localparam logic [SHIFT_W-1:0] TEN_SHIFT = 6'd28;
   localparam logic [RECIP_W-1:0] TEN_RECIP =
      RECIP_W'(((64'd1 << TEN_SHIFT) + 64'(TENTHS_SCALE - 1)) / 64'(TENTHS_SCALE));

   // Configuration port
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 3;

   localparam logic [CSR_IDX_W-1:0] REG_DUTY_AT_ZERO      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DUTY_AT_FULL      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_STEP_LIMIT        = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_HOLD_MS           = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_WAIT_SCALE_TENTHS = 3'd4;

   localparam logic [DUTY_W-1:0]  RST_DUTY_AT_ZERO      = 16'd3800;
   localparam logic [DUTY_W-1:0]  RST_DUTY_AT_FULL      = 16'd1835;
   localparam logic [STEP_W-1:0]  RST_STEP_LIMIT        = 8'd7;
   localparam logic [HOLD_W-1:0]  RST_HOLD_MS           = 10'd20;
   localparam logic [SCALE_W-1:0] RST_WAIT_SCALE_TENTHS = 8'd27;

   typedef struct packed {
      logic [DUTY_W-1:0]  duty_at_zero;
      logic [DUTY_W-1:0]  duty_at_full;
      logic [STEP_W-1:0]  step_limit;
      logic [HOLD_W-1:0]  hold_ms;
      logic [SCALE_W-1:0] wait_scale_tenths;
   } cfg_type;

   typedef struct packed {
      logic               start;
      logic [DIV_W-1:0]   dividend;
      logic [RECIP_W-1:0] recip;
      logic [SHIFT_W-1:0] shift;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_rsp_type;

endpackage

// ===== hdl/decimating_mean_servo_step_limiter.sv =====
// ----------------------------------------------------------------------------
// decimating_mean_servo_step_limiter
// Averages groups of force-sensor samples, maps the mean onto a servo duty
// range and limits each duty move to one step, with a wait time per result.
// ----------------------------------------------------------------------------
// A sample that does not complete a group is taken while the block stays idle
// and gives no result. The sample that completes a group starts a sequence
// that runs its divisions (group mean, the two duty mappings by 4095 and,
// for an unclipped move, the wait by tenths) as reciprocal multiplications
// through one shared multiply-and-shift unit. req_stall is high for the whole
// sequence and while the finished result waits for an earlier unread word.
// The finished result sits in an output register, so the next group's
// samples are taken while it waits to be read.
// ----------------------------------------------------------------------------
module decimating_mean_servo_step_limiter
   import dmssl_pkg::*;
#(
   parameter int GROUP_SIZE = 5
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [SAMPLE_W-1:0]   req_sample,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [DUTY_W-1:0]     rsp_duty,
   output logic [WAIT_W-1:0]     rsp_wait_ms,
   output logic                  rsp_limited,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int                 CNT_W       = $clog2(GROUP_SIZE + 1);
   localparam logic [CNT_W-1:0]   LAST_COUNT  = CNT_W'(GROUP_SIZE - 1);
   // exact for any group sum below 2^SUM_W
   localparam logic [SHIFT_W-1:0] GROUP_SHIFT = SHIFT_W'(SUM_W + $clog2(GROUP_SIZE));
   localparam logic [RECIP_W-1:0] GROUP_RECIP =
      RECIP_W'(((64'd1 << GROUP_SHIFT) + 64'(GROUP_SIZE - 1)) / 64'(GROUP_SIZE));

   typedef enum logic [3:0] {
      S_IDLE, S_MEAN_GO, S_MEAN_WAIT, S_MAP_MUL, S_MAP_GO, S_MAP_WAIT,
      S_DIFF, S_DECIDE, S_WAIT_GO, S_WAIT_WAIT, S_EMIT
   } state_type;

   cfg_type     cfg;
   div_req_type div_req;
   div_rsp_type div_rsp;

   state_type                  state_ff;
   logic [SUM_W-1:0]           sum_ff;
   logic [CNT_W-1:0]           count_ff;
   logic [MEAN_W-1:0]          prev_mean_ff;
   logic [MEAN_W-1:0]          mean_ff;
   logic                       map_new_ff;
   logic signed [PROD_W-1:0]   prod_ff;
   logic [DUTY_W-1:0]          pre_duty_ff;
   logic [DUTY_W-1:0]          new_duty_ff;
   logic [DUTY_W-1:0]          diff_ff;
   logic                       up_ff;
   logic [WPROD_W-1:0]         wprod_ff;
   logic [DUTY_W-1:0]          res_duty_ff;
   logic [WAIT_W-1:0]          res_wait_ff;
   logic                       res_lim_ff;
   logic                       rsp_valid_ff;
   logic [DUTY_W-1:0]          rsp_duty_ff;
   logic [WAIT_W-1:0]          rsp_wait_ff;
   logic                       rsp_lim_ff;

   logic                       accept;
   logic                       out_free;
   logic [SUM_W-1:0]           sum_next;
   logic [MEAN_W-1:0]          mean_op;
   logic signed [DUTY_W:0]     span;
   logic signed [PROD_W-1:0]   map_prod;
   logic signed [PROD_W-1:0]   prod_neg;
   logic [DIV_W-1:0]           prod_mag;
   logic [DUTY_W+1:0]          mapped_sum;
   logic [DUTY_W-1:0]          mapped;
   logic                       new_up;
   logic [DUTY_W-1:0]          new_diff;
   logic [DUTY_W-1:0]          step_ext;
   logic                       small_move;
   logic [WPROD_W-1:0]         wprod;
   logic [DUTY_W-1:0]          step_duty;
   logic [WAIT_W-1:0]          wait_sat;

   dmssl_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   dmssl_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // handshakes
   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign sum_next  = sum_ff + SUM_W'(req_sample);

   // mapping: signed mean * span, then magnitude for the divider
   assign mean_op  = map_new_ff ? mean_ff : prev_mean_ff;
   assign span     = $signed({1'b0, cfg.duty_at_full}) - $signed({1'b0, cfg.duty_at_zero});
   assign map_prod = PROD_W'($signed({1'b0, mean_op})) * PROD_W'(span);
   assign prod_neg = -prod_ff;
   assign prod_mag = prod_ff[PROD_W-1] ? prod_neg[DIV_W-1:0] : prod_ff[DIV_W-1:0];

   // duty = start +/- truncated quotient
   always_comb begin
      if (prod_ff[PROD_W-1])
         mapped_sum = {2'b00, cfg.duty_at_zero} - {2'b00, div_rsp.quotient[DUTY_W-1:0]};
      else
         mapped_sum = {2'b00, cfg.duty_at_zero} + {2'b00, div_rsp.quotient[DUTY_W-1:0]};
   end
   assign mapped = mapped_sum[DUTY_W-1:0];

   // move size and direction
   assign new_up   = new_duty_ff > pre_duty_ff;
   assign new_diff = new_up ? (new_duty_ff - pre_duty_ff) : (pre_duty_ff - new_duty_ff);

   // step decision and wait product
   assign step_ext   = DUTY_W'(cfg.step_limit);
   assign small_move = diff_ff < step_ext;
   assign wprod      = WPROD_W'(diff_ff) * WPROD_W'(cfg.wait_scale_tenths);
   assign step_duty  = up_ff ? (pre_duty_ff + step_ext) : (pre_duty_ff - step_ext);
   assign wait_sat   = (div_rsp.quotient[DIV_W-1:WAIT_W] != '0) ? '1
                       : div_rsp.quotient[WAIT_W-1:0];

   // divider requests
   always_comb begin
      div_req.start    = 1'b0;
      div_req.dividend = DIV_W'(sum_ff);
      div_req.recip    = GROUP_RECIP;
      div_req.shift    = GROUP_SHIFT;
      case (state_ff)
         S_MEAN_GO: begin
            div_req.start = 1'b1;
         end
         S_MAP_GO: begin
            div_req.start    = 1'b1;
            div_req.dividend = prod_mag;
            div_req.recip    = MAP_RECIP;
            div_req.shift    = MAP_SHIFT;
         end
         S_WAIT_GO: begin
            div_req.start    = 1'b1;
            div_req.dividend = DIV_W'(wprod_ff);
            div_req.recip    = TEN_RECIP;
            div_req.shift    = TEN_SHIFT;
         end
         default: ;
      endcase
   end

   // sequencer, state and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sum_ff       <= '0;
         count_ff     <= '0;
         prev_mean_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && state_ff != S_EMIT)
            rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  sum_ff <= sum_next;
                  if (count_ff == LAST_COUNT) begin
                     count_ff <= '0;
                     state_ff <= S_MEAN_GO;
                  end else begin
                     count_ff <= count_ff + 1'b1;
                  end
               end
            end
            S_MEAN_GO: begin
               state_ff <= S_MEAN_WAIT;
            end
            S_MEAN_WAIT: begin
               if (div_rsp.done) begin
                  mean_ff    <= div_rsp.quotient[MEAN_W-1:0];
                  sum_ff     <= '0;
                  map_new_ff <= 1'b0;
                  state_ff   <= S_MAP_MUL;
               end
            end
            S_MAP_MUL: begin
               prod_ff  <= map_prod;
               state_ff <= S_MAP_GO;
            end
            S_MAP_GO: begin
               state_ff <= S_MAP_WAIT;
            end
            S_MAP_WAIT: begin
               if (div_rsp.done) begin
                  if (map_new_ff) begin
                     new_duty_ff <= mapped;
                     state_ff    <= S_DIFF;
                  end else begin
                     pre_duty_ff <= mapped;
                     map_new_ff  <= 1'b1;
                     state_ff    <= S_MAP_MUL;
                  end
               end
            end
            S_DIFF: begin
               diff_ff  <= new_diff;
               up_ff    <= new_up;
               state_ff <= S_DECIDE;
            end
            S_DECIDE: begin
               prev_mean_ff <= mean_ff;
               wprod_ff     <= wprod;
               if (small_move) begin
                  res_duty_ff <= new_duty_ff;
                  res_lim_ff  <= 1'b0;
                  state_ff    <= S_WAIT_GO;
               end else begin
                  res_duty_ff <= step_duty;
                  res_wait_ff <= WAIT_W'(cfg.hold_ms);
                  res_lim_ff  <= 1'b1;
                  state_ff    <= S_EMIT;
               end
            end
            S_WAIT_GO: begin
               state_ff <= S_WAIT_WAIT;
            end
            S_WAIT_WAIT: begin
               if (div_rsp.done) begin
                  res_wait_ff <= wait_sat;
                  state_ff    <= S_EMIT;
               end
            end
            S_EMIT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_duty_ff  <= res_duty_ff;
                  rsp_wait_ff  <= res_wait_ff;
                  rsp_lim_ff   <= res_lim_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_duty    = rsp_duty_ff;
   assign rsp_wait_ms = rsp_wait_ff;
   assign rsp_limited = rsp_lim_ff;

   // a completed group starts the mean division with the counter cleared
   a_group_start: assert property (@(posedge clock) disable iff (reset)
      (accept && count_ff == LAST_COUNT) |=> (state_ff == S_MEAN_GO && count_ff == '0))
      else $error("completed group did not start the sequence");

   // a pending word is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT && rsp_valid_ff && rsp_stall) |=> state_ff == S_EMIT)
      else $error("result loaded over a pending word");

   // a new word only comes out of the emit state
   a_valid_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_EMIT)
      else $error("result valid raised outside emit");

endmodule

// ===== hdl/dmssl_divider.sv =====
// ----------------------------------------------------------------------------
// dmssl_divider
// Shared divide-by-constant unit: multiplies the dividend by a reciprocal and
// shifts the product down, with the product and then the quotient registered;
// done pulses for one cycle with the quotient held after it.
// ----------------------------------------------------------------------------
module dmssl_divider
   import dmssl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic                 busy_ff;
   logic                 done_ff;
   logic [MPROD_W-1:0]   prod_ff;
   logic [SHIFT_W-1:0]   shift_ff;
   logic [DIV_W-1:0]     quot_ff;

   logic [MPROD_W-1:0]   prod_shifted;

   assign prod_shifted = prod_ff >> shift_ff;

   // control: a multiply step, then a shift step
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= div_req.start && !busy_ff;
         done_ff <= busy_ff;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (div_req.start && !busy_ff) begin
         prod_ff  <= MPROD_W'(div_req.dividend) * MPROD_W'(div_req.recip);
         shift_ff <= div_req.shift;
      end
      if (busy_ff)
         quot_ff <= prod_shifted[DIV_W-1:0];
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quot_ff;

   // a new division is only requested when the unit is free
   a_start_when_free: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !busy_ff)
      else $error("divider started while busy");

   // done follows an accepted start through the busy register
   a_fixed_latency: assert property (@(posedge clock) disable iff (reset)
      (div_req.start && !busy_ff) |-> ##2 done_ff)
      else $error("divider done not at fixed latency");

endmodule

// ===== hdl/dmssl_csr.sv =====
// ----------------------------------------------------------------------------
// dmssl_csr
// APB-style register file holding the mapping, step and wait settings.
// ----------------------------------------------------------------------------
module dmssl_csr
   import dmssl_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type                cfg_ff;
   logic                   wr_en;
   logic [CSR_IDX_W-1:0]   reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = paddr[CSR_ADDR_W-1:2];

   // register writes, unknown indexes ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.duty_at_zero      <= RST_DUTY_AT_ZERO;
         cfg_ff.duty_at_full      <= RST_DUTY_AT_FULL;
         cfg_ff.step_limit        <= RST_STEP_LIMIT;
         cfg_ff.hold_ms           <= RST_HOLD_MS;
         cfg_ff.wait_scale_tenths <= RST_WAIT_SCALE_TENTHS;
      end else if (wr_en) begin
         case (reg_idx)
            REG_DUTY_AT_ZERO:      cfg_ff.duty_at_zero      <= pwdata[DUTY_W-1:0];
            REG_DUTY_AT_FULL:      cfg_ff.duty_at_full      <= pwdata[DUTY_W-1:0];
            REG_STEP_LIMIT:        cfg_ff.step_limit        <= pwdata[STEP_W-1:0];
            REG_HOLD_MS:           cfg_ff.hold_ms           <= pwdata[HOLD_W-1:0];
            REG_WAIT_SCALE_TENTHS: cfg_ff.wait_scale_tenths <= pwdata[SCALE_W-1:0];
            default: ;
         endcase
      end
   end

   // read mux
   always_comb begin
      case (reg_idx)
         REG_DUTY_AT_ZERO:      prdata = CSR_DATA_W'(cfg_ff.duty_at_zero);
         REG_DUTY_AT_FULL:      prdata = CSR_DATA_W'(cfg_ff.duty_at_full);
         REG_STEP_LIMIT:        prdata = CSR_DATA_W'(cfg_ff.step_limit);
         REG_HOLD_MS:           prdata = CSR_DATA_W'(cfg_ff.hold_ms);
         REG_WAIT_SCALE_TENTHS: prdata = CSR_DATA_W'(cfg_ff.wait_scale_tenths);
         default:               prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the decimating mean servo step limiter. Samples are
// sent over the req channel and mirrored in an in-bench model of the group
// averaging, the duty mapping and the step limit. Every result word is
// checked field by field, in order, against the predicted moves. The bench
// also exercises register settings, random idle on both sides and a long
// result back-pressure.
// ----------------------------------------------------------------------------
module tb_top;
   import dmssl_pkg::*;

   localparam int GROUP_SIZE    = 5;
   localparam int SETTLE_CYCLES = 150;   // longer than one group's computation
   localparam int QUIET_LIMIT   = 4000;
   localparam int HOLD_CYCLES   = 800;
   localparam int MAX_REPORTS   = 10;
   localparam int MAX_READING   = 4095;

   // Index past the end of the register map
   localparam logic [CSR_IDX_W-1:0] REG_UNMAPPED = 3'd5;

   typedef struct {
      logic [DUTY_W-1:0] duty;
      logic [WAIT_W-1:0] wait_ms;
      logic              limited;
   } servo_move_type;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_stall;
   logic [SAMPLE_W-1:0]   req_sample  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall   = 1'b0;
   logic [DUTY_W-1:0]     rsp_duty;
   logic [WAIT_W-1:0]     rsp_wait_ms;
   logic                  rsp_limited;
   logic                  psel        = 1'b0;
   logic                  penable     = 1'b0;
   logic                  pwrite      = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr       = '0;
   logic [CSR_DATA_W-1:0] pwdata      = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // Mirror of the block's settings and averaging state
   cfg_type            servo_cfg;
   logic [SUM_W-1:0]   group_sum;
   logic [5:0]         group_count;
   logic [MEAN_W-1:0]  prev_mean;
   servo_move_type     pending_moves[$];

   int mismatches    = 0;
   int send_idle_pct = 0;
   int stall_pct     = 0;
   int quiet_cycles  = 0;
   int hold_left     = 0;
   int hold_asked    = 0;
   int hold_served   = 0;
   int walk_level    = 2048;

   decimating_mean_servo_step_limiter #(.GROUP_SIZE(GROUP_SIZE)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_sample  (req_sample),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_duty    (rsp_duty),
      .rsp_wait_ms (rsp_wait_ms),
      .rsp_limited (rsp_limited),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- model

   // Linear map of a mean onto the duty range, quotient truncated toward zero
   function automatic int duty_for_mean(input logic [MEAN_W-1:0] mean);
      int lo;
      int span;
      lo   = int'(servo_cfg.duty_at_zero);
      span = int'(servo_cfg.duty_at_full) - lo;
      return lo + (int'(mean) * span) / int'(FULL_SCALE);
   endfunction

   // Accumulate one sample; a completed group queues the expected move
   function automatic void absorb_sample(input logic [SAMPLE_W-1:0] sample);
      logic [SUM_W-1:0]  mean_wide;
      logic [MEAN_W-1:0] mean;
      int                pre_duty;
      int                new_duty;
      int                diff;
      longint            scaled;
      servo_move_type    mv;
      group_sum   = group_sum + SUM_W'(sample);
      group_count = group_count + 6'd1;
      if (group_count != 6'(GROUP_SIZE)) return;
      mean_wide   = group_sum / SUM_W'(GROUP_SIZE);
      mean        = (mean_wide > SUM_W'(MAX_READING)) ? '1 : mean_wide[MEAN_W-1:0];
      group_sum   = '0;
      group_count = '0;
      pre_duty = duty_for_mean(prev_mean);
      new_duty = duty_for_mean(mean);
      diff     = new_duty - pre_duty;
      if (diff < 0) diff = -diff;
      if (diff < int'(servo_cfg.step_limit)) begin
         scaled     = longint'(diff) * longint'(servo_cfg.wait_scale_tenths) / 10;
         mv.duty    = DUTY_W'(new_duty);
         mv.wait_ms = (scaled > 65535) ? '1 : WAIT_W'(scaled);
         mv.limited = 1'b0;
      end else begin
         // one step toward the new duty; down unless the new duty is above
         if (new_duty > pre_duty) mv.duty = DUTY_W'(pre_duty + int'(servo_cfg.step_limit));
         else mv.duty = DUTY_W'(pre_duty - int'(servo_cfg.step_limit));
         mv.wait_ms = WAIT_W'(servo_cfg.hold_ms);
         mv.limited = 1'b1;
      end
      prev_mean = mean;
      pending_moves.push_back(mv);
   endfunction

   // ------------------------------------------------------------- checking

   function automatic void flag_error(input string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("%0t: %s", $time, msg);
   endfunction

   task automatic check_move();
      servo_move_type want;
      if (pending_moves.size() == 0) begin
         flag_error($sformatf("result word with none expected: duty %0d wait %0d limited %0d",
                              rsp_duty, rsp_wait_ms, rsp_limited));
         return;
      end
      want = pending_moves.pop_front();
      if (rsp_duty !== want.duty)
         flag_error($sformatf("duty: expected %0d, got %0d", want.duty, rsp_duty));
      if (rsp_wait_ms !== want.wait_ms)
         flag_error($sformatf("wait_ms: expected %0d, got %0d", want.wait_ms, rsp_wait_ms));
      if (rsp_limited !== want.limited)
         flag_error($sformatf("limited: expected %0d, got %0d", want.limited, rsp_limited));
   endtask

   // Result side: random stall or a long hold-off, then check accepted words
   always @(posedge clock) begin
      if (hold_served != hold_asked) begin
         hold_left   = HOLD_CYCLES;
         hold_served = hold_asked;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= (int'($urandom_range(99)) < stall_pct);
      end
      if (!reset && rsp_valid && !rsp_stall) check_move();
   end

   // Watchdog: too long without any word moving on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------- stimulus

   // Send one sample word, with random idle before it
   task automatic push_sample(input logic [SAMPLE_W-1:0] sample);
      while (int'($urandom_range(99)) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= sample;
      do @(posedge clock); while (req_stall);
      absorb_sample(sample);
   endtask

   task automatic push_repeated(input logic [SAMPLE_W-1:0] sample, input int count);
      repeat (count) push_sample(sample);
   endtask

   // Stop sending, wait for every expected word, then let the block go idle
   task automatic settle_block();
      req_valid <= 1'b0;
      while (pending_moves.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Two-phase register write; the model takes the masked value
   task automatic program_register(input logic [CSR_IDX_W-1:0] idx,
                                   input logic [CSR_DATA_W-1:0] value);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         REG_DUTY_AT_ZERO:      servo_cfg.duty_at_zero      = value[DUTY_W-1:0];
         REG_DUTY_AT_FULL:      servo_cfg.duty_at_full      = value[DUTY_W-1:0];
         REG_STEP_LIMIT:        servo_cfg.step_limit        = value[STEP_W-1:0];
         REG_HOLD_MS:           servo_cfg.hold_ms           = value[HOLD_W-1:0];
         REG_WAIT_SCALE_TENTHS: servo_cfg.wait_scale_tenths = value[SCALE_W-1:0];
         default: ;
      endcase
   endtask

   task automatic apply_settings(input logic [CSR_DATA_W-1:0] at_zero,
                                 input logic [CSR_DATA_W-1:0] at_full,
                                 input logic [CSR_DATA_W-1:0] step,
                                 input logic [CSR_DATA_W-1:0] hold,
                                 input logic [CSR_DATA_W-1:0] scale);
      settle_block();
      program_register(REG_DUTY_AT_ZERO, at_zero);
      program_register(REG_DUTY_AT_FULL, at_full);
      program_register(REG_STEP_LIMIT, step);
      program_register(REG_HOLD_MS, hold);
      program_register(REG_WAIT_SCALE_TENTHS, scale);
   endtask

   // Group mode: small walk around a level, uniform, or rail values
   function automatic logic [SAMPLE_W-1:0] pick_reading(input int mode);
      int v;
      if (mode < 65) v = walk_level + int'($urandom_range(16)) - 8;
      else if (mode < 90) v = int'($urandom_range(MAX_READING));
      else v = $urandom_range(1) ? MAX_READING : 0;
      if (v < 0) v = 0;
      if (v > MAX_READING) v = MAX_READING;
      return SAMPLE_W'(v);
   endfunction

   task automatic run_random_readings(input int count);
      int left_in_group;
      int mode;
      left_in_group = 0;
      mode          = 0;
      for (int i = 0; i < count; i++) begin
         if (left_in_group == 0) begin
            left_in_group = GROUP_SIZE;
            mode          = int'($urandom_range(99));
            walk_level    = walk_level + int'($urandom_range(48)) - 24;
            if (walk_level < 0) walk_level = 0;
            if (walk_level > MAX_READING) walk_level = MAX_READING;
         end
         push_sample(pick_reading(mode));
         left_in_group--;
      end
   endtask

   // ---------------------------------------------------------------- tests

   // Rails, both clipped directions, floor of the mean, small negative map
   task automatic test_directed_extremes();
      push_repeated(SAMPLE_W'(0), 5);
      push_repeated(SAMPLE_W'(MAX_READING), 5);
      push_repeated(SAMPLE_W'(MAX_READING), 4);
      push_sample(SAMPLE_W'(MAX_READING - 1));
      push_repeated(SAMPLE_W'(0), 5);
      push_repeated(SAMPLE_W'(10), 4);
      push_sample(SAMPLE_W'(14));
   endtask

   task automatic test_default_walk();
      run_random_readings(175);
   endtask

   // Full span upward with the widest step, hold and scale
   task automatic test_wide_span();
      apply_settings(0, 32'hFFFF, 32'hFF, 32'h3FF, 32'hFF);
      run_random_readings(150);
   endtask

   // Full span downward with the smallest step, no hold, no wait scale
   task automatic test_inverted_span();
      apply_settings(32'hFFFF, 0, 1, 0, 0);
      run_random_readings(150);
   endtask

   // Flat map: step limit zero clips every move, then step one passes them
   task automatic test_flat_span_no_step();
      apply_settings(1234, 1234, 0, 512, 1);
      run_random_readings(40);
      apply_settings(1234, 1234, 1, 512, 1);
      run_random_readings(20);
   endtask

   // Random full-width register words; groups straddle the writes
   task automatic test_random_registers();
      for (int r = 0; r < 3; r++) begin
         apply_settings($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
         if (r == 1) program_register(REG_UNMAPPED, $urandom());
         run_random_readings(97);
      end
   endtask

   // Long result hold-off so the block backs up and stalls its input
   task automatic test_output_backpressure();
      apply_settings(CSR_DATA_W'(RST_DUTY_AT_ZERO), CSR_DATA_W'(RST_DUTY_AT_FULL), 40,
                     CSR_DATA_W'(RST_HOLD_MS), CSR_DATA_W'(RST_WAIT_SCALE_TENTHS));
      for (int r = 0; r < 2; r++) begin
         hold_asked++;
         run_random_readings(25);
         settle_block();
      end
   endtask

   // ----------------------------------------------------------------- main

   initial begin
      servo_cfg.duty_at_zero      = RST_DUTY_AT_ZERO;
      servo_cfg.duty_at_full      = RST_DUTY_AT_FULL;
      servo_cfg.step_limit        = RST_STEP_LIMIT;
      servo_cfg.hold_ms           = RST_HOLD_MS;
      servo_cfg.wait_scale_tenths = RST_WAIT_SCALE_TENTHS;
      group_sum   = '0;
      group_count = '0;
      prev_mean   = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 10;
      stall_pct     = 71;
      test_directed_extremes();
      test_default_walk();
      test_wide_span();

      send_idle_pct = 71;
      stall_pct     = 10;
      test_inverted_span();
      test_flat_span_no_step();

      send_idle_pct = 0;
      stall_pct     = 0;
      test_random_registers();
      test_output_backpressure();

      settle_block();
      if (mismatches == 0 && pending_moves.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
